/* rtl/core/bilinear_coverage_blend_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bilinear coverage blend block
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_COVERAGE_BLEND_TOP_DEFINES_SVH
`define BILINEAR_COVERAGE_BLEND_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BCB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define BCB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bcb_pkg.sv */
// ----------------------------------------------------------------------------
// bcb_pkg
// Types and constants shared by the bilinear coverage blend pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bcb_pkg;

    // Field widths fixed by the interface.
    localparam int COORD_W  = 21;
    localparam int PIX_W    = 8;
    localparam int DIM_W    = 13;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    // Number of register stages from input to output.
    localparam int NSTAGE   = 5;

    // Register reset values and arithmetic constants.
    localparam logic [DIM_W-1:0] DIM_RESET  = 13'd4096;
    localparam logic [PIX_W-1:0] PIX_MAX    = 8'd255;
    localparam logic [PIX_W-1:0] ROUND_BIAS = 8'd127;

    // Register index, taken from the word address.
    typedef enum logic [0:0] {
        REG_SOURCE_WIDTH  = 1'b0,
        REG_SOURCE_HEIGHT = 1'b1
    } bcb_reg_idx_t;

    typedef logic [PIX_W-1:0] pix_t;

    // Source size as programmed.
    typedef struct packed {
        logic [DIM_W-1:0] source_width;
        logic [DIM_W-1:0] source_height;
    } bcb_cfg_t;

endpackage

`default_nettype wire

/* rtl/core/bcb_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bcb_cfg_regs
// APB register file holding the source bitmap width and height.
// ----------------------------------------------------------------------------
`default_nettype none

module bcb_cfg_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [bcb_pkg::APB_AW-1:0] paddr,
    input  wire logic [bcb_pkg::APB_DW-1:0] pwdata,
    output logic      [bcb_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    output bcb_pkg::bcb_cfg_t               cfg
);
    import bcb_pkg::*;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] width_next;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] height_next;
    bcb_reg_idx_t     reg_idx;
    logic             wr_en;

    // Registers are word aligned, so the index is the word address bit.
    assign reg_idx = bcb_reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Write decode.
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_SOURCE_WIDTH:  width_next  = pwdata[DIM_W-1:0];
                REG_SOURCE_HEIGHT: height_next = pwdata[DIM_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Read decode.
    always_comb
    begin
        unique case (reg_idx)
            REG_SOURCE_WIDTH:  prdata = APB_DW'(width_reg);
            REG_SOURCE_HEIGHT: prdata = APB_DW'(height_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.source_width  = width_reg;
    assign cfg.source_height = height_reg;

endmodule

`default_nettype wire

/* rtl/core/bcb_sample_mask.sv */
// ----------------------------------------------------------------------------
// bcb_sample_mask
// First stage: splits the position and zeroes neighbours outside the source.
// ----------------------------------------------------------------------------
`default_nettype none

module bcb_sample_mask #(
    parameter int FRAC_BITS      = 8,
    parameter int MAX_SOURCE_DIM = 4096
) (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  bcb_pkg::bcb_cfg_t                        cfg,
    input  wire logic signed [bcb_pkg::COORD_W-1:0]  src_x_fixed,
    input  wire logic signed [bcb_pkg::COORD_W-1:0]  src_y_fixed,
    input  bcb_pkg::pix_t                            sample_top_left,
    input  bcb_pkg::pix_t                            sample_top_right,
    input  bcb_pkg::pix_t                            sample_bottom_left,
    input  bcb_pkg::pix_t                            sample_bottom_right,
    input  bcb_pkg::pix_t                            dest_coverage,
    output bcb_pkg::pix_t                            s_tl,
    output bcb_pkg::pix_t                            s_tr,
    output bcb_pkg::pix_t                            s_bl,
    output bcb_pkg::pix_t                            s_br,
    output logic             [FRAC_BITS-1:0]         fx,
    output logic             [FRAC_BITS-1:0]         fy,
    output bcb_pkg::pix_t                            dst
);
    import bcb_pkg::*;

    // Integer part width, and a compare width that holds it and the size limit.
    localparam int IW   = COORD_W - FRAC_BITS;
    localparam int CMPW = (IW + 1 > 17) ? IW + 1 : 17;
    localparam logic signed [IW:0]   ONE_S   = (IW + 1)'(1);
    localparam logic [CMPW-1:0]      DIM_MAX = CMPW'(MAX_SOURCE_DIM);

    logic signed [IW:0]     x0;
    logic signed [IW:0]     x1;
    logic signed [IW:0]     y0;
    logic signed [IW:0]     y1;
    logic [CMPW-1:0]        w_lim;
    logic [CMPW-1:0]        h_lim;
    logic                   xl;
    logic                   xr;
    logic                   yt;
    logic                   yb;

    pix_t                   s_tl_reg, s_tl_next;
    pix_t                   s_tr_reg, s_tr_next;
    pix_t                   s_bl_reg, s_bl_next;
    pix_t                   s_br_reg, s_br_next;
    logic [FRAC_BITS-1:0]   fx_reg, fx_next;
    logic [FRAC_BITS-1:0]   fy_reg, fy_next;
    pix_t                   dst_reg, dst_next;

    // A coordinate lies inside when it is not negative and below the limit.
    function automatic logic coord_in(input logic signed [IW:0] c,
                                      input logic [CMPW-1:0] lim);
        logic [CMPW-1:0] cu;
        cu = CMPW'(unsigned'(c));
        return !c[IW] && (cu < lim);
    endfunction

    // Floor of the position is an arithmetic shift; the fraction is the low bits.
    assign x0 = (IW + 1)'(src_x_fixed >>> FRAC_BITS);
    assign y0 = (IW + 1)'(src_y_fixed >>> FRAC_BITS);
    assign x1 = x0 + ONE_S;
    assign y1 = y0 + ONE_S;

    // Source size, limited to the largest supported dimension.
    assign w_lim = (CMPW'(cfg.source_width) > DIM_MAX) ? DIM_MAX
                                                        : CMPW'(cfg.source_width);
    assign h_lim = (CMPW'(cfg.source_height) > DIM_MAX) ? DIM_MAX
                                                         : CMPW'(cfg.source_height);

    assign xl = coord_in(x0, w_lim);
    assign xr = coord_in(x1, w_lim);
    assign yt = coord_in(y0, h_lim);
    assign yb = coord_in(y1, h_lim);

    // Neighbours outside the bitmap read as empty.
    always_comb
    begin
        s_tl_next = (xl && yt) ? sample_top_left     : '0;
        s_tr_next = (xr && yt) ? sample_top_right    : '0;
        s_bl_next = (xl && yb) ? sample_bottom_left  : '0;
        s_br_next = (xr && yb) ? sample_bottom_right : '0;
        fx_next   = src_x_fixed[FRAC_BITS-1:0];
        fy_next   = src_y_fixed[FRAC_BITS-1:0];
        dst_next  = dest_coverage;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_tl_reg <= s_tl_next;
            s_tr_reg <= s_tr_next;
            s_bl_reg <= s_bl_next;
            s_br_reg <= s_br_next;
            fx_reg   <= fx_next;
            fy_reg   <= fy_next;
            dst_reg  <= dst_next;
        end
    end

    assign s_tl = s_tl_reg;
    assign s_tr = s_tr_reg;
    assign s_bl = s_bl_reg;
    assign s_br = s_br_reg;
    assign fx   = fx_reg;
    assign fy   = fy_reg;
    assign dst  = dst_reg;

endmodule

`default_nettype wire

/* rtl/core/bcb_interp.sv */
// ----------------------------------------------------------------------------
// bcb_interp
// Two stages of bilinear interpolation: along x, then along y with rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module bcb_interp #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                   clk,
    input  wire logic                   en_h,
    input  wire logic                   en_v,
    input  bcb_pkg::pix_t               s_tl,
    input  bcb_pkg::pix_t               s_tr,
    input  bcb_pkg::pix_t               s_bl,
    input  bcb_pkg::pix_t               s_br,
    input  wire logic [FRAC_BITS-1:0]   fx,
    input  wire logic [FRAC_BITS-1:0]   fy,
    input  bcb_pkg::pix_t               dst_in,
    output bcb_pkg::pix_t               src,
    output bcb_pkg::pix_t               dst_out
);
    import bcb_pkg::*;

    // Row sums carry FRAC_BITS fraction bits, the final sum twice that.
    localparam int TW = PIX_W + FRAC_BITS;
    localparam int MW = PIX_W + 2 * FRAC_BITS;
    localparam logic [FRAC_BITS:0] ONE_F = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [MW:0]        HALF  = (MW + 1)'(1) << (2 * FRAC_BITS - 1);

    logic [FRAC_BITS:0]     wx;
    logic [FRAC_BITS:0]     wy;
    logic [TW:0]            top_sum;
    logic [TW:0]            bot_sum;
    logic [MW:0]            mid_sum;
    logic [MW:0]            mid_rnd;
    logic [PIX_W:0]         src_wide;

    logic [TW-1:0]          top_reg, top_next;
    logic [TW-1:0]          bot_reg, bot_next;
    logic [FRAC_BITS-1:0]   fy_reg, fy_next;
    pix_t                   dst_h_reg, dst_h_next;
    pix_t                   src_reg, src_next;
    pix_t                   dst_v_reg, dst_v_next;

    // Horizontal pass over the top and bottom rows.
    assign wx      = ONE_F - {1'b0, fx};
    assign top_sum = (TW + 1)'(s_tl) * (TW + 1)'(wx) + (TW + 1)'(s_tr) * (TW + 1)'(fx);
    assign bot_sum = (TW + 1)'(s_bl) * (TW + 1)'(wx) + (TW + 1)'(s_br) * (TW + 1)'(fx);

    always_comb
    begin
        top_next   = top_sum[TW-1:0];
        bot_next   = bot_sum[TW-1:0];
        fy_next    = fy;
        dst_h_next = dst_in;
    end

    always_ff @(posedge clk)
    begin
        if (en_h)
        begin
            top_reg   <= top_next;
            bot_reg   <= bot_next;
            fy_reg    <= fy_next;
            dst_h_reg <= dst_h_next;
        end
    end

    // Vertical pass, rounded half up and clamped to the pixel range.
    assign wy       = ONE_F - {1'b0, fy_reg};
    assign mid_sum  = (MW + 1)'(top_reg) * (MW + 1)'(wy)
                    + (MW + 1)'(bot_reg) * (MW + 1)'(fy_reg);
    assign mid_rnd  = mid_sum + HALF;
    assign src_wide = mid_rnd[MW:2*FRAC_BITS];

    always_comb
    begin
        src_next   = (src_wide > {1'b0, PIX_MAX}) ? PIX_MAX : src_wide[PIX_W-1:0];
        dst_v_next = dst_h_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_v)
        begin
            src_reg   <= src_next;
            dst_v_reg <= dst_v_next;
        end
    end

    assign src     = src_reg;
    assign dst_out = dst_v_reg;

endmodule

`default_nettype wire

/* rtl/core/bcb_blend.sv */
// ----------------------------------------------------------------------------
// bcb_blend
// Two stages of over-blend of the sampled source onto the destination.
// ----------------------------------------------------------------------------
`default_nettype none

module bcb_blend (
    input  wire logic       clk,
    input  wire logic       en_m,
    input  wire logic       en_o,
    input  bcb_pkg::pix_t   src,
    input  bcb_pkg::pix_t   dst,
    output bcb_pkg::pix_t   blended
);
    import bcb_pkg::*;

    localparam int PW = 2 * PIX_W;

    logic [PW:0]        qsum;
    pix_t               quot;

    logic [PW-1:0]      prod_reg, prod_next;
    pix_t               src_reg, src_next;
    pix_t               dst_reg, dst_next;
    pix_t               blended_reg, blended_next;

    // Scaled destination share plus the rounding bias.
    always_comb
    begin
        prod_next = PW'(dst) * PW'(PIX_MAX - src) + PW'(ROUND_BIAS);
        src_next  = src;
        dst_next  = dst;
    end

    always_ff @(posedge clk)
    begin
        if (en_m)
        begin
            prod_reg <= prod_next;
            src_reg  <= src_next;
            dst_reg  <= dst_next;
        end
    end

    // Exact division by 255 for this range: (x + (x >> 8) + 1) >> 8.
    assign qsum = (PW + 1)'(prod_reg) + (PW + 1)'(prod_reg[PW-1:PIX_W]) + (PW + 1)'(1);
    assign quot = qsum[PW-1:PIX_W];

    // Empty source keeps the destination; full source or empty destination
    // takes the source.
    always_comb
    begin
        if (src_reg == '0)
        begin
            blended_next = dst_reg;
        end
        else if ((src_reg == PIX_MAX) || (dst_reg == '0))
        begin
            blended_next = src_reg;
        end
        else
        begin
            blended_next = src_reg + quot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_o)
        begin
            blended_reg <= blended_next;
        end
    end

    assign blended = blended_reg;

endmodule

`default_nettype wire

/* rtl/core/bilinear_coverage_blend_top.sv */
// Accepted data passes the mask, horizontal, vertical, product and output registers.
// Throughput: one transaction per cycle while out_stall is low; each of the five stages holds one item.
// A stall at the output holds the last stage, and stages behind it fill any bubble
// before in_stall rises, so the input stalls only when all five stages are full.
// Reset clears every stage valid bit and sets both source dimensions to 4096.
// ----------------------------------------------------------------------------
// bilinear_coverage_blend_top
// Samples an 8-bit coverage glyph bilinearly and blends it over the destination.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_coverage_blend_top #(
    parameter int FRAC_BITS      = 8,
    parameter int MAX_SOURCE_DIM = 4096
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [bcb_pkg::COORD_W-1:0]  src_x_fixed,
    input  wire logic signed [bcb_pkg::COORD_W-1:0]  src_y_fixed,
    input  wire logic        [bcb_pkg::PIX_W-1:0]    sample_top_left,
    input  wire logic        [bcb_pkg::PIX_W-1:0]    sample_top_right,
    input  wire logic        [bcb_pkg::PIX_W-1:0]    sample_bottom_left,
    input  wire logic        [bcb_pkg::PIX_W-1:0]    sample_bottom_right,
    input  wire logic        [bcb_pkg::PIX_W-1:0]    dest_coverage,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic             [bcb_pkg::PIX_W-1:0]    blended_coverage,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic        [bcb_pkg::APB_AW-1:0]   paddr,
    input  wire logic        [bcb_pkg::APB_DW-1:0]   pwdata,
    output logic             [bcb_pkg::APB_DW-1:0]   prdata,
    output logic                                     pready
);
    import bcb_pkg::*;

    logic [NSTAGE-1:0]      v_reg;
    logic [NSTAGE-1:0]      v_next;
    logic [NSTAGE-1:0]      ce;

    bcb_cfg_t               cfg;
    pix_t                   s_tl, s_tr, s_bl, s_br, dst_s1;
    logic [FRAC_BITS-1:0]   fx, fy;
    pix_t                   src_s3, dst_s3;

    // A stage may load when it is empty or the stage after it moves on.
    always_comb
    begin
        ce[NSTAGE-1] = !v_reg[NSTAGE-1] || !out_stall;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            ce[i] = !v_reg[i] || ce[i+1];
        end
    end

    // Valid bits travel with the data.
    always_comb
    begin
        v_next = v_reg;
        if (ce[0])
        begin
            v_next[0] = in_valid;
        end
        for (int i = 1; i < NSTAGE; i++)
        begin
            if (ce[i])
            begin
                v_next[i] = v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_stall  = !ce[0];
    assign out_valid = v_reg[NSTAGE-1];

    // Configuration registers.
    bcb_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage one: neighbour masking.
    bcb_sample_mask #(
        .FRAC_BITS      (FRAC_BITS),
        .MAX_SOURCE_DIM (MAX_SOURCE_DIM)
    ) u_mask (
        .clk                 (clk),
        .en                  (ce[0]),
        .cfg                 (cfg),
        .src_x_fixed         (src_x_fixed),
        .src_y_fixed         (src_y_fixed),
        .sample_top_left     (sample_top_left),
        .sample_top_right    (sample_top_right),
        .sample_bottom_left  (sample_bottom_left),
        .sample_bottom_right (sample_bottom_right),
        .dest_coverage       (dest_coverage),
        .s_tl                (s_tl),
        .s_tr                (s_tr),
        .s_bl                (s_bl),
        .s_br                (s_br),
        .fx                  (fx),
        .fy                  (fy),
        .dst                 (dst_s1)
    );

    // Stages two and three: interpolation.
    bcb_interp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_interp (
        .clk     (clk),
        .en_h    (ce[1]),
        .en_v    (ce[2]),
        .s_tl    (s_tl),
        .s_tr    (s_tr),
        .s_bl    (s_bl),
        .s_br    (s_br),
        .fx      (fx),
        .fy      (fy),
        .dst_in  (dst_s1),
        .src     (src_s3),
        .dst_out (dst_s3)
    );

    // Stages four and five: blend and output register.
    bcb_blend u_blend (
        .clk     (clk),
        .en_m    (ce[3]),
        .en_o    (ce[4]),
        .src     (src_s3),
        .dst     (dst_s3),
        .blended (blended_coverage)
    );

endmodule

`default_nettype wire

/* rtl/core/bcb_checker.sv */
// ----------------------------------------------------------------------------
// bcb_checker
// Port-level checks on the pixel channels of the blend block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bilinear_coverage_blend_top_defines.svh"

module bcb_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall
);

    // A result that is held back stays offered.
    `BCB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "out_valid dropped while stalled")

    // The input only stalls when the output is itself held back.
    `BCB_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall, "in_stall without output stall")

    // With the output free throughout, an accepted transaction is offered at the output.
    `BCB_ASSERT_NEXT(a_latency, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall, out_valid, "result missing after pipeline latency")

endmodule

bind bilinear_coverage_blend_top bcb_checker u_bcb_checker (.*);

`default_nettype wire

/* tb/sv/bilinear_coverage_blend_top_tb.sv */
// ----------------------------------------------------------------------------
// Bilinear coverage blend testbench
// Programs the source size over the register port, sends pixel transactions
// and checks every blended coverage value against an in-bench predictor of
// the sampling, edge handling, rounding and over-blend rules.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_coverage_blend_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bcb_pkg::*;

    // Predictor constants, matching the block's default parameters.
    localparam int FRAC        = 8;
    localparam int MAX_DIM     = 4096;
    localparam int CHUNKS      = 5;
    localparam int CHUNK_ITEMS = 70;
    localparam int CYCLE_LIMIT = 200000;

    // One pixel transaction as presented on the input ports.
    typedef struct packed {
        logic signed [COORD_W-1:0] x_fixed;
        logic signed [COORD_W-1:0] y_fixed;
        pix_t                      top_left;
        pix_t                      top_right;
        pix_t                      bottom_left;
        pix_t                      bottom_right;
        pix_t                      dest;
    } pixel_txn_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic signed [COORD_W-1:0] src_x_fixed = '0;
    logic signed [COORD_W-1:0] src_y_fixed = '0;
    pix_t                      sample_top_left = '0;
    pix_t                      sample_top_right = '0;
    pix_t                      sample_bottom_left = '0;
    pix_t                      sample_bottom_right = '0;
    pix_t                      dest_coverage = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    pix_t                      blended_coverage;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_AW-1:0]         paddr = '0;
    logic [APB_DW-1:0]         pwdata = '0;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;

    // Shadow copy of the size registers and the store of expected coverage.
    logic [DIM_W-1:0] width_shadow = DIM_RESET;
    logic [DIM_W-1:0] height_shadow = DIM_RESET;
    pix_t             coverage_expected[$];
    int               mismatch_count = 0;
    int               cycle_count = 0;
    int               sender_idle_pct = 24;
    int               receiver_idle_pct = 79;

    bilinear_coverage_blend_top uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .src_x_fixed         (src_x_fixed),
        .src_y_fixed         (src_y_fixed),
        .sample_top_left     (sample_top_left),
        .sample_top_right    (sample_top_right),
        .sample_bottom_left  (sample_bottom_left),
        .sample_bottom_right (sample_bottom_right),
        .dest_coverage       (dest_coverage),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .blended_coverage    (blended_coverage),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    // Clock with an 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Give up on a run that never finishes.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Every mismatch prints one line and is counted.
    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        $display("[%0t] mismatch: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Works out the blended coverage for one pixel under the current size.
    function automatic pix_t predict_blend(pixel_txn_t t);
        int     x_whole, y_whole, fx, fy, w, h, src, dst;
        int     s_tl, s_tr, s_bl, s_br;
        longint top, bottom, mid;
        bit     x_left, x_right, y_top, y_bottom;
        x_whole  = int'(t.x_fixed) >>> FRAC;
        y_whole  = int'(t.y_fixed) >>> FRAC;
        fx       = int'(t.x_fixed[FRAC-1:0]);
        fy       = int'(t.y_fixed[FRAC-1:0]);
        w        = (width_shadow > MAX_DIM) ? MAX_DIM : int'(width_shadow);
        h        = (height_shadow > MAX_DIM) ? MAX_DIM : int'(height_shadow);
        x_left   = (x_whole >= 0) && (x_whole < w);
        x_right  = (x_whole + 1 >= 0) && (x_whole + 1 < w);
        y_top    = (y_whole >= 0) && (y_whole < h);
        y_bottom = (y_whole + 1 >= 0) && (y_whole + 1 < h);
        // Neighbours outside the source contribute nothing.
        s_tl   = (x_left && y_top) ? int'(t.top_left) : 0;
        s_tr   = (x_right && y_top) ? int'(t.top_right) : 0;
        s_bl   = (x_left && y_bottom) ? int'(t.bottom_left) : 0;
        s_br   = (x_right && y_bottom) ? int'(t.bottom_right) : 0;
        top    = s_tl * ((1 << FRAC) - fx) + s_tr * fx;
        bottom = s_bl * ((1 << FRAC) - fx) + s_br * fx;
        mid    = top * ((1 << FRAC) - fy) + bottom * fy;
        src    = int'((mid + (64'd1 << (2 * FRAC - 1))) >> (2 * FRAC));
        if (src > int'(PIX_MAX))
            src = int'(PIX_MAX);
        // Over-blend onto the destination.
        dst = int'(t.dest);
        if (src == 0)
            return pix_t'(dst);
        if (src == int'(PIX_MAX) || dst == 0)
            return pix_t'(src);
        return pix_t'(src + (dst * (int'(PIX_MAX) - src) + int'(ROUND_BIAS))
                      / int'(PIX_MAX));
    endfunction

    // Receiver stalls at random at the falling edge.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end

    // Each accepted result is checked against the oldest expectation.
    always @(posedge clk)
    begin
        pix_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (coverage_expected.size() == 0)
                report_mismatch("blended_coverage with nothing pending",
                                int'(blended_coverage), -1);
            else
            begin
                want = coverage_expected.pop_front();
                if (blended_coverage !== want)
                    report_mismatch("blended_coverage", int'(blended_coverage), int'(want));
            end
        end
    end

    // Sends one pixel transaction and records its expected result.
    task automatic send_pixel(pixel_txn_t t);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid            <= 1'b1;
        src_x_fixed         <= t.x_fixed;
        src_y_fixed         <= t.y_fixed;
        sample_top_left     <= t.top_left;
        sample_top_right    <= t.top_right;
        sample_bottom_left  <= t.bottom_left;
        sample_bottom_right <= t.bottom_right;
        dest_coverage       <= t.dest;
        do
            @(posedge clk);
        while (in_stall);
        coverage_expected.push_back(predict_blend(t));
        @(negedge clk);
    endtask

    // Stops sending and waits until the pipeline has emptied.
    task automatic settle_pipeline();
        in_valid <= 1'b0;
        while (coverage_expected.size() != 0)
            @(posedge clk);
        repeat (NSTAGE + 2) @(negedge clk);
    endtask

    // One register transfer: setup cycle, then access cycle.
    task automatic apb_access(input bcb_reg_idx_t idx, input logic write,
                              input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Reads a size register back and compares it with the shadow copy.
    task automatic check_size_register(bcb_reg_idx_t idx);
        logic [APB_DW-1:0] readback;
        logic [DIM_W-1:0]  want;
        want = (idx == REG_SOURCE_WIDTH) ? width_shadow : height_shadow;
        apb_access(idx, 1'b0, '0, readback);
        if (readback !== APB_DW'(want))
            report_mismatch(idx.name(), int'(readback), int'(want));
    endtask

    // Writes a size register once the block is idle.
    task automatic program_size(bcb_reg_idx_t idx, logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] unused;
        settle_pipeline();
        apb_access(idx, 1'b1, value, unused);
        if (idx == REG_SOURCE_WIDTH)
            width_shadow = value[DIM_W-1:0];
        else
            height_shadow = value[DIM_W-1:0];
        check_size_register(idx);
    endtask

    function automatic pixel_txn_t make_pixel(int x, int y, int tl, int tr, int bl,
                                              int br, int dst);
        pixel_txn_t t;
        t.x_fixed      = COORD_W'(x);
        t.y_fixed      = COORD_W'(y);
        t.top_left     = pix_t'(tl);
        t.top_right    = pix_t'(tr);
        t.bottom_left  = pix_t'(bl);
        t.bottom_right = pix_t'(br);
        t.dest         = pix_t'(dst);
        return t;
    endfunction

    // Picks a coordinate mostly around the source, sometimes anywhere.
    function automatic logic [COORD_W-1:0] pick_coord(int span);
        int whole, frac;
        case ($urandom_range(0, 9))
            0: return COORD_W'($urandom);
            1: whole = ($urandom_range(0, 1) ? span : 0) - int'($urandom_range(0, 1));
            default: whole = int'($urandom_range(0, span + 3)) - 2;
        endcase
        if (whole > MAX_DIM - 1)
            whole = MAX_DIM - 1;
        if (whole < -MAX_DIM)
            whole = -MAX_DIM;
        case ($urandom_range(0, 9))
            0, 1: frac = 0;
            2: frac = (1 << FRAC) - 1;
            3: frac = 1 << (FRAC - 1);
            default: frac = int'($urandom_range(0, (1 << FRAC) - 1));
        endcase
        return COORD_W'(whole * (1 << FRAC) + frac);
    endfunction

    // Coverage values lean towards empty and full.
    function automatic pix_t pick_coverage();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return PIX_MAX;
            default: return pix_t'($urandom);
        endcase
    endfunction

    function automatic pixel_txn_t random_pixel();
        pixel_txn_t t;
        int         w, h;
        w              = (width_shadow > MAX_DIM) ? MAX_DIM : int'(width_shadow);
        h              = (height_shadow > MAX_DIM) ? MAX_DIM : int'(height_shadow);
        t.x_fixed      = pick_coord(w);
        t.y_fixed      = pick_coord(h);
        t.top_left     = pick_coverage();
        t.top_right    = pick_coverage();
        t.bottom_left  = pick_coverage();
        t.bottom_right = pick_coverage();
        t.dest         = pick_coverage();
        return t;
    endfunction

    // Source sizes: mostly small, with zero, full and oversized values mixed in.
    function automatic logic [APB_DW-1:0] pick_dim();
        logic [APB_DW-1:0] value;
        case ($urandom_range(0, 19))
            0: value = 0;
            1: value = MAX_DIM;
            2: value = 8191;
            3: value = $urandom_range(MAX_DIM + 1, 8191);
            4, 5: value = $urandom_range(1, MAX_DIM);
            default: value = $urandom_range(1, 16);
        endcase
        // Bits above the register width should be dropped by the block.
        if ($urandom_range(0, 9) == 0)
            value = value | ($urandom << DIM_W);
        return value;
    endfunction

    // Reset sizes read back, and the far edges of the default source.
    task automatic test_reset_state();
        check_size_register(REG_SOURCE_WIDTH);
        check_size_register(REG_SOURCE_HEIGHT);
        send_pixel(make_pixel(4095 * 256 + 128, 10 * 256, 200, 99, 50, 7, 30));
        send_pixel(make_pixel(10 * 256, 4095 * 256 + 255, 1, 2, 3, 4, 5));
        send_pixel(make_pixel(1048575, 1048575, 255, 255, 255, 255, 0));
    endtask

    // Blend rules, rounding and the extremes of the position fields.
    task automatic test_directed_blend();
        send_pixel(make_pixel(0, 0, 200, 9, 9, 9, 0));
        send_pixel(make_pixel(128, 128, 255, 255, 255, 255, 77));
        send_pixel(make_pixel(300, 700, 0, 0, 0, 0, 77));
        send_pixel(make_pixel(64, 192, 100, 20, 180, 40, 255));
        send_pixel(make_pixel(5 * 256, 5 * 256, 100, 0, 0, 0, 100));
        send_pixel(make_pixel(128, 0, 1, 0, 0, 0, 0));
        send_pixel(make_pixel(-128, -128, 11, 22, 33, 44, 0));
        send_pixel(make_pixel(-1048576, -1048576, 255, 255, 255, 255, 200));
        send_pixel(make_pixel(-1048576, 1048575, 90, 90, 90, 90, 1));
        send_pixel(make_pixel(255, 255, 0, 0, 0, 255, 1));
        send_pixel(make_pixel(7 * 256 + 1, 9 * 256 + 254, 255, 0, 255, 0, 254));
        send_pixel(make_pixel(20 * 256 + 37, 3 * 256 + 200, 17, 240, 99, 3, 128));
    endtask

    // Zero, one-pixel, oversized and masked source sizes.
    task automatic test_size_extremes();
        program_size(REG_SOURCE_WIDTH, 0);
        program_size(REG_SOURCE_HEIGHT, 5);
        send_pixel(make_pixel(0, 0, 200, 200, 200, 200, 66));
        program_size(REG_SOURCE_WIDTH, 8191);
        program_size(REG_SOURCE_HEIGHT, 4097);
        send_pixel(make_pixel(4095 * 256 + 128, 4095 * 256 + 128, 180, 70, 60, 50, 40));
        program_size(REG_SOURCE_WIDTH, 1);
        program_size(REG_SOURCE_HEIGHT, 1);
        send_pixel(make_pixel(0, 0, 33, 44, 55, 66, 10));
        send_pixel(make_pixel(128, 128, 240, 250, 250, 250, 10));
        program_size(REG_SOURCE_WIDTH, 32'hFFFF_E003);
        program_size(REG_SOURCE_HEIGHT, 32'h0000_2002);
        send_pixel(make_pixel(2 * 256 + 128, 1 * 256 + 128, 120, 130, 140, 150, 160));
    endtask

    // Random pixels under a series of random source sizes.
    task automatic test_random_traffic(int send_pct, int recv_pct);
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        repeat (CHUNKS)
        begin
            program_size(REG_SOURCE_WIDTH, pick_dim());
            program_size(REG_SOURCE_HEIGHT, pick_dim());
            repeat (CHUNK_ITEMS) send_pixel(random_pixel());
        end
    endtask

    // Test sequence.
    initial
    begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_state();
        test_directed_blend();
        test_size_extremes();
        test_random_traffic(24, 79);
        test_random_traffic(79, 24);
        test_random_traffic(0, 0);
        settle_pipeline();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl/core
rtl/core/bcb_pkg.sv
rtl/core/bcb_cfg_regs.sv
rtl/core/bcb_sample_mask.sv
rtl/core/bcb_interp.sv
rtl/core/bcb_blend.sv
rtl/core/bilinear_coverage_blend_top.sv
rtl/core/bcb_checker.sv
tb/sv/bilinear_coverage_blend_top_tb.sv
